// ===== rtl/sfcs_pkg.sv =====
`timescale 1ns / 1ps

package sfcs_pkg;

   // host operation codes
   localparam logic [3:0] OP_RDSTATUS = 4'd0;
   localparam logic [3:0] OP_WREN     = 4'd1;
   localparam logic [3:0] OP_SECTOR   = 4'd2;
   localparam logic [3:0] OP_ERASE32  = 4'd3;
   localparam logic [3:0] OP_ERASE64  = 4'd4;
   localparam logic [3:0] OP_CHIP     = 4'd5;
   localparam logic [3:0] OP_READ     = 4'd6;
   localparam logic [3:0] OP_PROGRAM  = 4'd7;
   localparam logic [3:0] OP_RECEIVED = 4'd8;

   localparam logic [2:0] CMD_RDSTATUS = 3'd0;
   localparam logic [2:0] CMD_WREN     = 3'd1;
   localparam logic [2:0] CMD_SECTOR   = 3'd2;
   localparam logic [2:0] CMD_ERASE32  = 3'd3;
   localparam logic [2:0] CMD_ERASE64  = 3'd4;
   localparam logic [2:0] CMD_CHIP     = 3'd5;
   localparam logic [2:0] CMD_READ     = 3'd6;
   localparam logic [2:0] CMD_PROGRAM  = 3'd7;

   // flash opcodes and status bits
   localparam logic [7:0] FL_RDSR  = 8'h05;
   localparam logic [7:0] FL_WREN  = 8'h06;
   localparam logic [7:0] FL_SE    = 8'h20;
   localparam logic [7:0] FL_BE32  = 8'h52;
   localparam logic [7:0] FL_BE64  = 8'hD8;
   localparam logic [7:0] FL_CE    = 8'hC7;
   localparam logic [7:0] FL_READ  = 8'h03;
   localparam logic [7:0] FL_PP    = 8'h02;
   localparam logic [7:0] FL_DUMMY = 8'hFF;
   localparam int         BUSY_BIT = 0;
   localparam int         WEL_BIT  = 1;

   localparam logic KIND_BUS  = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_P1_CMD   = 4'd1,
      PH_P1_DAT   = 4'd2,
      PH_WREN     = 4'd3,
      PH_P2_CMD   = 4'd4,
      PH_P2_DAT   = 4'd5,
      PH_P3_CMD   = 4'd6,
      PH_P3_DAT   = 4'd7,
      PH_MAIN     = 4'd8,
      PH_RDSR_CMD = 4'd9,
      PH_RDSR_DAT = 4'd10
   } phase_type;

   typedef struct packed {
      logic [3:0]  operation;
      logic [23:0] flash_address;
      logic [7:0]  write_byte;
      logic [7:0]  received_byte;
   } req_item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic       frame_start;
      logic       frame_end;
      logic [7:0] result_byte;
   } rsp_item_type;

   function automatic logic [7:0] opcode_of(input logic [2:0] cmd);
      logic [7:0] code;
      case (cmd)
         CMD_RDSTATUS: code = FL_RDSR;
         CMD_WREN:     code = FL_WREN;
         CMD_SECTOR:   code = FL_SE;
         CMD_ERASE32:  code = FL_BE32;
         CMD_ERASE64:  code = FL_BE64;
         CMD_CHIP:     code = FL_CE;
         CMD_READ:     code = FL_READ;
         default:      code = FL_PP;
      endcase
      return code;
   endfunction

   function automatic logic [2:0] frame_len_of(input logic [2:0] cmd);
      logic [2:0] len;
      case (cmd)
         CMD_SECTOR, CMD_ERASE32, CMD_ERASE64: len = 3'd4;
         CMD_READ, CMD_PROGRAM:                len = 3'd5;
         default:                              len = 3'd1;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/sfcs_chan_if.sv =====
`timescale 1ns / 1ps

interface sfcs_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [23:0] flash_address;
   logic [7:0]  write_byte;
   logic [7:0]  received_byte;

   modport source (output valid, operation, flash_address, write_byte, received_byte,
                   input ready);
   modport sink (input valid, operation, flash_address, write_byte, received_byte,
                 output ready);
endinterface

interface sfcs_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] tx_byte;
   logic       frame_start;
   logic       frame_end;
   logic [7:0] result_byte;

   modport source (output valid, kind, tx_byte, frame_start, frame_end, result_byte,
                   input ready);
   modport sink (input valid, kind, tx_byte, frame_start, frame_end, result_byte,
                 output ready);
endinterface

// ===== rtl/sfcs_core.sv =====
`timescale 1ns / 1ps

module sfcs_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  sfcs_pkg::req_item_type item,
   output logic                  res_valid,
   output sfcs_pkg::rsp_item_type res
);

   sfcs_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [23:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic [2:0]  idx_ff, idx_in;

   logic [2:0] len;
   logic [2:0] idx_next;
   logic       is_rx;
   logic       is_cmd;
   logic [7:0] rx;

   assign len      = sfcs_pkg::frame_len_of(cmd_ff);
   assign idx_next = idx_ff + 3'd1;
   assign is_rx    = (item.operation == sfcs_pkg::OP_RECEIVED);
   assign is_cmd   = (item.operation <= sfcs_pkg::OP_PROGRAM);
   assign rx       = item.received_byte;

   function automatic logic [7:0] main_byte(input logic [2:0] idx, input logic [2:0] cmd,
                                            input logic [23:0] addr, input logic [7:0] data);
      logic [7:0] b;
      case (idx)
         3'd0:    b = sfcs_pkg::opcode_of(cmd);
         3'd1:    b = addr[23:16];
         3'd2:    b = addr[15:8];
         3'd3:    b = addr[7:0];
         default: b = (cmd == sfcs_pkg::CMD_PROGRAM) ? data : sfcs_pkg::FL_DUMMY;
      endcase
      return b;
   endfunction

   // next state
   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      data_in  = data_ff;
      idx_in   = idx_ff;
      case (phase_ff)
         sfcs_pkg::PH_P1_CMD, sfcs_pkg::PH_P2_CMD,
         sfcs_pkg::PH_P3_CMD, sfcs_pkg::PH_RDSR_CMD: begin
            if (is_rx) phase_in = sfcs_pkg::phase_type'(phase_ff + 4'd1);
         end
         sfcs_pkg::PH_P1_DAT: begin
            if (is_rx) phase_in = rx[sfcs_pkg::BUSY_BIT] ? sfcs_pkg::PH_P1_CMD
                                                          : sfcs_pkg::PH_WREN;
         end
         sfcs_pkg::PH_WREN: begin
            if (is_rx) phase_in = sfcs_pkg::PH_P2_CMD;
         end
         sfcs_pkg::PH_P2_DAT: begin
            if (is_rx) begin
               if (!rx[sfcs_pkg::WEL_BIT])            phase_in = sfcs_pkg::PH_P2_CMD;
               else if (cmd_ff == sfcs_pkg::CMD_WREN) phase_in = sfcs_pkg::PH_IDLE;
               else                                   phase_in = sfcs_pkg::PH_P3_CMD;
            end
         end
         sfcs_pkg::PH_P3_DAT: begin
            if (is_rx) begin
               if (rx[sfcs_pkg::BUSY_BIT]) begin
                  phase_in = sfcs_pkg::PH_P3_CMD;
               end else begin
                  phase_in = sfcs_pkg::PH_MAIN;
                  idx_in   = 3'd0;
               end
            end
         end
         sfcs_pkg::PH_MAIN: begin
            if (is_rx) begin
               if (idx_next >= len) begin
                  phase_in = sfcs_pkg::PH_IDLE;
                  idx_in   = 3'd0;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         sfcs_pkg::PH_RDSR_DAT: begin
            if (is_rx) phase_in = sfcs_pkg::PH_IDLE;
         end
         default: begin
            // idle, or a code that means nothing: take a new command
            phase_in = sfcs_pkg::PH_IDLE;
            if (is_cmd) begin
               cmd_in  = item.operation[2:0];
               addr_in = item.flash_address;
               data_in = item.write_byte;
               idx_in  = 3'd0;
               if (item.operation == sfcs_pkg::OP_RDSTATUS)
                  phase_in = sfcs_pkg::PH_RDSR_CMD;
               else if (item.operation[2:0] == sfcs_pkg::CMD_READ)
                  phase_in = sfcs_pkg::PH_P3_CMD;
               else
                  phase_in = sfcs_pkg::PH_P1_CMD;
            end
         end
      endcase
   end

   // result
   always_comb begin
      res_valid       = 1'b0;
      res.kind        = sfcs_pkg::KIND_BUS;
      res.tx_byte     = 8'h00;
      res.frame_start = 1'b0;
      res.frame_end   = 1'b0;
      res.result_byte = 8'h00;
      case (phase_ff)
         sfcs_pkg::PH_P1_CMD, sfcs_pkg::PH_P2_CMD,
         sfcs_pkg::PH_P3_CMD, sfcs_pkg::PH_RDSR_CMD: begin
            res_valid     = is_rx;
            res.tx_byte   = sfcs_pkg::FL_DUMMY;
            res.frame_end = 1'b1;
         end
         sfcs_pkg::PH_P1_DAT: begin
            res_valid       = is_rx;
            res.frame_start = 1'b1;
            if (rx[sfcs_pkg::BUSY_BIT]) begin
               res.tx_byte = sfcs_pkg::FL_RDSR;
            end else begin
               res.tx_byte   = sfcs_pkg::FL_WREN;
               res.frame_end = 1'b1;
            end
         end
         sfcs_pkg::PH_WREN: begin
            res_valid       = is_rx;
            res.tx_byte     = sfcs_pkg::FL_RDSR;
            res.frame_start = 1'b1;
         end
         sfcs_pkg::PH_P2_DAT: begin
            res_valid = is_rx;
            if (rx[sfcs_pkg::WEL_BIT] && cmd_ff == sfcs_pkg::CMD_WREN) begin
               res.kind        = sfcs_pkg::KIND_DONE;
               res.result_byte = rx;
            end else begin
               res.tx_byte     = sfcs_pkg::FL_RDSR;
               res.frame_start = 1'b1;
            end
         end
         sfcs_pkg::PH_P3_DAT: begin
            res_valid       = is_rx;
            res.frame_start = 1'b1;
            if (rx[sfcs_pkg::BUSY_BIT]) begin
               res.tx_byte = sfcs_pkg::FL_RDSR;
            end else begin
               res.tx_byte   = main_byte(3'd0, cmd_ff, addr_ff, data_ff);
               res.frame_end = (len == 3'd1);
            end
         end
         sfcs_pkg::PH_MAIN: begin
            res_valid = is_rx;
            if (idx_next >= len) begin
               res.kind        = sfcs_pkg::KIND_DONE;
               res.result_byte = (cmd_ff == sfcs_pkg::CMD_READ) ? rx : 8'h00;
            end else begin
               res.tx_byte   = main_byte(idx_next, cmd_ff, addr_ff, data_ff);
               res.frame_end = (idx_next + 3'd1 == len);
            end
         end
         sfcs_pkg::PH_RDSR_DAT: begin
            res_valid       = is_rx;
            res.kind        = sfcs_pkg::KIND_DONE;
            res.result_byte = rx;
         end
         default: begin
            res_valid       = is_cmd;
            res.tx_byte     = sfcs_pkg::FL_RDSR;
            res.frame_start = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfcs_pkg::PH_IDLE;
         cmd_ff   <= 3'd0;
         addr_ff  <= 24'd0;
         data_ff  <= 8'd0;
         idx_ff   <= 3'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/spi_flash_command_sequencer_unit.sv =====
`timescale 1ns / 1ps

// SPI NOR flash command sequencer.
// req_chan (sink): host commands (operations 0..7) and reply bytes from the
//   SPI shifter (operation 8). A command is taken only while the sequencer
//   is idle; anything that does not fit the current phase is dropped with no
//   response.
// rsp_chan (source): bus bytes to shift out (kind 0, with chip-select start
//   and end marks) and one done item (kind 1) per command carrying the status
//   byte, the read byte, or zero for erase and program.
// Path: a request transfer lands in the input register; when the sequencer
//   steps, any response is loaded into the output register, from which it
//   transfers on rsp_chan.
// Throughput: one request per cycle unless stalled. The phase update is a
//   single step of the state machine between the input and output registers.
// Stall: when rsp_chan is held off, the output register holds its item,
//   the input register holds one more request, and req_chan.ready drops.
// Reset (synchronous): both registers empty, phase idle, held command,
//   address, data and frame index cleared.
module spi_flash_command_sequencer_unit (
   input logic        clock,
   input logic        reset,
   sfcs_req_if.sink   req_chan,
   sfcs_rsp_if.source rsp_chan
);

   logic                   in_valid_ff, in_valid_in;
   sfcs_pkg::req_item_type in_item_ff, in_item_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sfcs_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic                   advance;
   logic                   res_valid;
   sfcs_pkg::rsp_item_type res;

   // step the sequencer when a request is held and the output slot frees up
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   sfcs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (in_item_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_chan.ready) begin
         in_valid_in              = req_chan.valid;
         in_item_in.operation     = req_chan.operation;
         in_item_in.flash_address = req_chan.flash_address;
         in_item_in.write_byte    = req_chan.write_byte;
         in_item_in.received_byte = req_chan.received_byte;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
         rsp_item_in  = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_item_ff.kind;
   assign rsp_chan.tx_byte     = rsp_item_ff.tx_byte;
   assign rsp_chan.frame_start = rsp_item_ff.frame_start;
   assign rsp_chan.frame_end   = rsp_item_ff.frame_end;
   assign rsp_chan.result_byte = rsp_item_ff.result_byte;

endmodule
